>>> rtl/core/ecr_pkg.sv
// ============================================================================
// ecr_pkg - shared types and a helper for the 2D elastic contact resolver
// Payload structs for both channels, the context carried down the pipe,
// and the 32-bit saturation helper.
// ============================================================================
package ecr_pkg;

    localparam int ECR_FRAC_BITS = 16;  // fraction bits of the mass factors
    localparam int ECR_NORM_BITS = 14;  // fraction bits of the normal (Q2.14)
    localparam int ECR_DEN_W     = 33;  // m1 + m2
    localparam int ECR_U_W       = 36;  // normal speed component width

    typedef struct packed {
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic        [30:0] depth;
        logic signed [31:0] offset_x;
        logic signed [31:0] offset_y;
        logic signed [31:0] speed_a_x;
        logic signed [31:0] speed_a_y;
        logic signed [31:0] speed_b_x;
        logic signed [31:0] speed_b_y;
        logic        [31:0] mass_a;
        logic        [31:0] mass_b;
        logic        [3:0]  body_flags;
    } ecr_in_t;

    typedef struct packed {
        logic signed [31:0] push_a_x;
        logic signed [31:0] push_a_y;
        logic signed [31:0] push_b_x;
        logic signed [31:0] push_b_y;
        logic signed [31:0] new_speed_a_x;
        logic signed [31:0] new_speed_a_y;
        logic signed [31:0] new_speed_b_x;
        logic signed [31:0] new_speed_b_y;
        logic               resolved;
    } ecr_out_t;

    // body_flags bit positions
    localparam int FLAG_TRIG_A = 0;
    localparam int FLAG_STAT_A = 1;
    localparam int FLAG_TRIG_B = 2;
    localparam int FLAG_STAT_B = 3;

    // per-contact context that rides along the divider and back end
    typedef struct packed {
        logic signed [16:0]          nx;
        logic signed [16:0]          ny;
        logic signed [ECR_U_W-1:0]   ua;
        logic signed [ECR_U_W-1:0]   ub;
        logic signed [31:0]          vax;
        logic signed [31:0]          vay;
        logic signed [31:0]          vbx;
        logic signed [31:0]          vby;
        logic signed [31:0]          pax;
        logic signed [31:0]          pay;
        logic signed [31:0]          pbx;
        logic signed [31:0]          pby;
        logic                        diff_neg;
        logic                        stat_a;
        logic                        stat_b;
        logic                        res;
    } ecr_ctx_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > 64'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (x < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/core/ecr_front.sv
// ============================================================================
// ecr_front - contact setup
// Stage 1: flip test, mass sum and difference. Stage 2: oriented normal,
// normal speeds, pushes and divider numerators.
// ============================================================================
module ecr_front #(
    parameter int FRAC_BITS = ecr_pkg::ECR_FRAC_BITS
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  ecr_pkg::ecr_in_t                      in_data,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output ecr_pkg::ecr_ctx_t                     out_ctx,
    output logic [ecr_pkg::ECR_DEN_W-1:0]         out_den,
    output logic [FRAC_BITS+33:0]                 out_num_d,
    output logic [FRAC_BITS+33:0]                 out_num_a,
    output logic [FRAC_BITS+33:0]                 out_num_b
);
    import ecr_pkg::*;

    localparam int NW = FRAC_BITS + 34;

    function automatic logic signed [35:0] rnd14(input logic signed [49:0] x);
        logic signed [49:0] y;
        y = x + 50'sd8192;
        return y[49:14];
    endfunction

    // ---- stage 1 ----
    logic signed [47:0] dot_x, dot_y;
    logic signed [48:0] dot;
    logic               m_zero;
    logic [31:0]        m1, m2;

    assign dot_x  = in_data.normal_x * in_data.offset_x;
    assign dot_y  = in_data.normal_y * in_data.offset_y;
    assign dot    = 49'(dot_x) + 49'(dot_y);
    assign m_zero = (in_data.mass_a == 32'd0) && (in_data.mass_b == 32'd0);
    assign m1     = m_zero ? 32'd1 : in_data.mass_a;
    assign m2     = m_zero ? 32'd1 : in_data.mass_b;

    logic            v1_reg, v2_reg;
    logic            r1, r2;
    ecr_in_t         item1_reg;
    logic            flip1_reg, dneg1_reg;
    logic [31:0]     m1_reg, m2_reg, diff1_reg;
    logic [ECR_DEN_W-1:0] sum1_reg;

    assign r2       = !v2_reg || out_ready;
    assign r1       = !v1_reg || r2;
    assign in_ready = r1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (r1) begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (r1) begin
            item1_reg <= in_data;
            flip1_reg <= dot[48];
            m1_reg    <= m1;
            m2_reg    <= m2;
            sum1_reg  <= 33'(m1) + 33'(m2);
            dneg1_reg <= m1 < m2;
            diff1_reg <= (m1 >= m2) ? (m1 - m2) : (m2 - m1);
        end
    end

    // ---- stage 2 ----
    logic signed [16:0] nx17, ny17, nfx, nfy;
    logic signed [48:0] pax_p, pay_p, pbx_p, pby_p;
    logic signed [49:0] ua_s, ub_s;
    logic signed [32:0] d2;
    logic signed [49:0] ppx, ppy;
    logic signed [35:0] prx, pry;
    logic               t_a, s_a, t_b, s_b, res, push_a_on, push_b_on;
    logic [ECR_DEN_W-1:0] half;
    ecr_ctx_t           ctx;

    assign nx17 = {item1_reg.normal_x[15], item1_reg.normal_x};
    assign ny17 = {item1_reg.normal_y[15], item1_reg.normal_y};
    assign nfx  = flip1_reg ? -nx17 : nx17;
    assign nfy  = flip1_reg ? -ny17 : ny17;

    assign pax_p = nfx * item1_reg.speed_a_x;
    assign pay_p = nfy * item1_reg.speed_a_y;
    assign pbx_p = nfx * item1_reg.speed_b_x;
    assign pby_p = nfy * item1_reg.speed_b_y;
    assign ua_s  = 50'(pax_p) + 50'(pay_p);
    assign ub_s  = 50'(pbx_p) + 50'(pby_p);

    assign d2  = {1'b0, item1_reg.depth, 1'b0};
    assign ppx = d2 * nfx;
    assign ppy = d2 * nfy;
    assign prx = rnd14(ppx);
    assign pry = rnd14(ppy);

    assign t_a = item1_reg.body_flags[FLAG_TRIG_A];
    assign s_a = item1_reg.body_flags[FLAG_STAT_A];
    assign t_b = item1_reg.body_flags[FLAG_TRIG_B];
    assign s_b = item1_reg.body_flags[FLAG_STAT_B];
    assign res = !t_a && !t_b && !(s_a && s_b);
    assign push_a_on = res && !s_a && s_b;
    assign push_b_on = res && s_a && !s_b;
    assign half = sum1_reg >> 1;

    always_comb begin
        ctx.nx       = nfx;
        ctx.ny       = nfy;
        ctx.ua       = rnd14(ua_s);
        ctx.ub       = rnd14(ub_s);
        ctx.vax      = item1_reg.speed_a_x;
        ctx.vay      = item1_reg.speed_a_y;
        ctx.vbx      = item1_reg.speed_b_x;
        ctx.vby      = item1_reg.speed_b_y;
        ctx.pax      = push_a_on ? sat32(64'(prx)) : 32'sd0;
        ctx.pay      = push_a_on ? sat32(64'(pry)) : 32'sd0;
        ctx.pbx      = push_b_on ? sat32(-64'(prx)) : 32'sd0;
        ctx.pby      = push_b_on ? sat32(-64'(pry)) : 32'sd0;
        ctx.diff_neg = dneg1_reg;
        ctx.stat_a   = s_a;
        ctx.stat_b   = s_b;
        ctx.res      = res;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (r2) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (r2) begin
            out_ctx   <= ctx;
            out_den   <= sum1_reg;
            out_num_d <= (NW'(diff1_reg) << FRAC_BITS) + NW'(half);
            out_num_a <= (NW'({m2_reg, 1'b0}) << FRAC_BITS) + NW'(half);
            out_num_b <= (NW'({m1_reg, 1'b0}) << FRAC_BITS) + NW'(half);
        end
    end

    assign out_valid = v2_reg;

endmodule

>>> rtl/core/ecr_divider.sv
// ============================================================================
// ecr_divider - pipelined restoring divider, three lanes
// One quotient bit per stage for the three mass factors, shared divisor.
// ============================================================================
module ecr_divider #(
    parameter int FRAC_BITS = ecr_pkg::ECR_FRAC_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  ecr_pkg::ecr_ctx_t             in_ctx,
    input  logic [ecr_pkg::ECR_DEN_W-1:0] in_den,
    input  logic [FRAC_BITS+33:0]         in_num_d,
    input  logic [FRAC_BITS+33:0]         in_num_a,
    input  logic [FRAC_BITS+33:0]         in_num_b,
    output logic                          out_valid,
    input  logic                          out_ready,
    output ecr_pkg::ecr_ctx_t             out_ctx,
    output logic [FRAC_BITS+1:0]          out_q_d,
    output logic [FRAC_BITS+1:0]          out_q_a,
    output logic [FRAC_BITS+1:0]          out_q_b
);
    import ecr_pkg::*;

    localparam int NW = FRAC_BITS + 34;
    localparam int QW = FRAC_BITS + 2;
    localparam int RW = ECR_DEN_W;

    logic [RW-1:0]        rem_reg  [QW][3];
    logic [QW-1:0]        work_reg [QW][3];
    logic [RW-1:0]        den_reg  [QW];
    ecr_ctx_t             ctx_reg  [QW];
    logic                 v_reg    [QW];
    logic                 rdy      [QW];

    logic [NW-1:0]        num [3];
    assign num[0] = in_num_d;
    assign num[1] = in_num_a;
    assign num[2] = in_num_b;

    genvar s, k;
    generate
        for (s = 0; s < QW; s++) begin : g_stage
            logic [RW-1:0] rem_i  [3];
            logic [QW-1:0] work_i [3];
            logic [RW-1:0] den_i;
            ecr_ctx_t      ctx_i;
            logic          v_i;

            if (s == 0) begin : g_first
                for (k = 0; k < 3; k++) begin : g_init
                    assign rem_i[k]  = RW'(num[k][NW-1:QW]);
                    assign work_i[k] = num[k][QW-1:0];
                end
                assign den_i = in_den;
                assign ctx_i = in_ctx;
                assign v_i   = in_valid;
            end else begin : g_next
                for (k = 0; k < 3; k++) begin : g_link
                    assign rem_i[k]  = rem_reg[s-1][k];
                    assign work_i[k] = work_reg[s-1][k];
                end
                assign den_i = den_reg[s-1];
                assign ctx_i = ctx_reg[s-1];
                assign v_i   = v_reg[s-1];
            end

            if (s == QW - 1) begin : g_last_rdy
                assign rdy[s] = !v_reg[s] || out_ready;
            end else begin : g_mid_rdy
                assign rdy[s] = !v_reg[s] || rdy[s+1];
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    v_reg[s] <= 1'b0;
                end else if (rdy[s]) begin
                    v_reg[s] <= v_i;
                end
            end

            for (k = 0; k < 3; k++) begin : g_lane
                logic [RW:0] trial;
                logic        ge;
                assign trial = {rem_i[k], work_i[k][QW-1]};
                assign ge    = trial >= {1'b0, den_i};

                always_ff @(posedge aclk) begin
                    if (rdy[s]) begin
                        rem_reg[s][k]  <= ge ? RW'(trial - {1'b0, den_i}) : trial[RW-1:0];
                        work_reg[s][k] <= {work_i[k][QW-2:0], ge};
                    end
                end
            end

            always_ff @(posedge aclk) begin
                if (rdy[s]) begin
                    den_reg[s] <= den_i;
                    ctx_reg[s] <= ctx_i;
                end
            end
        end
    endgenerate

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[QW-1];
    assign out_ctx   = ctx_reg[QW-1];
    assign out_q_d   = work_reg[QW-1][0];
    assign out_q_a   = work_reg[QW-1][1];
    assign out_q_b   = work_reg[QW-1][2];

endmodule

>>> rtl/core/ecr_back.sv
// ============================================================================
// ecr_back - velocity update
// Stage 1: factor products. Stage 2: new normal speeds and deltas.
// Stage 3: project back on the normal, add, saturate, select; output register.
// ============================================================================
module ecr_back #(
    parameter int FRAC_BITS = ecr_pkg::ECR_FRAC_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  ecr_pkg::ecr_ctx_t     in_ctx,
    input  logic [FRAC_BITS+1:0]  in_q_d,
    input  logic [FRAC_BITS+1:0]  in_q_a,
    input  logic [FRAC_BITS+1:0]  in_q_b,
    output logic                  out_valid,
    input  logic                  out_ready,
    output ecr_pkg::ecr_out_t     out_data
);
    import ecr_pkg::*;

    localparam int QW = FRAC_BITS + 2;
    localparam int PW = QW + 1 + ECR_U_W;   // factor * normal speed
    localparam int SW = PW + 1;
    localparam int WW = SW - FRAC_BITS;     // new normal speed
    localparam int DW = WW + 1;             // w - u
    localparam int MW = 17 + DW;
    localparam int XW = MW - ECR_NORM_BITS;

    logic v1_reg, v2_reg, v3_reg, r1, r2, r3;
    assign r3       = !v3_reg || out_ready;
    assign r2       = !v2_reg || r3;
    assign r1       = !v1_reg || r2;
    assign in_ready = r1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (r1) v1_reg <= in_valid;
            if (r2) v2_reg <= v1_reg;
            if (r3) v3_reg <= v2_reg;
        end
    end

    // ---- stage 1 ----
    logic signed [QW:0]   qd_s, qa_s, qb_s;
    logic signed [PW-1:0] pda_reg, pdb_reg, pa_reg, pb_reg;
    ecr_ctx_t             ctx1_reg, ctx2_reg;

    assign qd_s = signed'({1'b0, in_q_d});
    assign qa_s = signed'({1'b0, in_q_a});
    assign qb_s = signed'({1'b0, in_q_b});

    always_ff @(posedge aclk) begin
        if (r1) begin
            pda_reg  <= qd_s * in_ctx.ua;
            pdb_reg  <= qd_s * in_ctx.ub;
            pa_reg   <= qa_s * in_ctx.ub;
            pb_reg   <= qb_s * in_ctx.ua;
            ctx1_reg <= in_ctx;
        end
    end

    // ---- stage 2 ----
    logic signed [SW-1:0] sa, sb, ya, yb;
    logic signed [WW-1:0] wa, wb;
    logic signed [DW-1:0] dwa_reg, dwb_reg;

    always_comb begin
        if (ctx1_reg.diff_neg) begin
            sa = SW'(pa_reg) - SW'(pda_reg);
            sb = SW'(pb_reg) + SW'(pdb_reg);
        end else begin
            sa = SW'(pa_reg) + SW'(pda_reg);
            sb = SW'(pb_reg) - SW'(pdb_reg);
        end
        ya = sa + (SW'(1) <<< (FRAC_BITS - 1));
        yb = sb + (SW'(1) <<< (FRAC_BITS - 1));
        wa = ya[SW-1:FRAC_BITS];
        wb = yb[SW-1:FRAC_BITS];
    end

    always_ff @(posedge aclk) begin
        if (r2) begin
            dwa_reg  <= DW'(wa) - DW'(ctx1_reg.ua);
            dwb_reg  <= DW'(wb) - DW'(ctx1_reg.ub);
            ctx2_reg <= ctx1_reg;
        end
    end

    // ---- stage 3 ----
    function automatic logic signed [31:0] upd(input logic signed [31:0] v,
                                               input logic signed [16:0] n,
                                               input logic signed [DW-1:0] dw);
        logic signed [MW-1:0] p;
        logic signed [MW-1:0] y;
        logic signed [XW-1:0] r;
        p = n * dw;
        y = p + MW'(8192);
        r = y[MW-1:ECR_NORM_BITS];
        return sat32(64'(r) + 64'(v));
    endfunction

    logic upd_a, upd_b;
    assign upd_a = ctx2_reg.res && !ctx2_reg.stat_a;
    assign upd_b = ctx2_reg.res && !ctx2_reg.stat_b;

    always_ff @(posedge aclk) begin
        if (r3) begin
            out_data.push_a_x      <= ctx2_reg.pax;
            out_data.push_a_y      <= ctx2_reg.pay;
            out_data.push_b_x      <= ctx2_reg.pbx;
            out_data.push_b_y      <= ctx2_reg.pby;
            out_data.new_speed_a_x <= upd_a ? upd(ctx2_reg.vax, ctx2_reg.nx, dwa_reg)
                                            : ctx2_reg.vax;
            out_data.new_speed_a_y <= upd_a ? upd(ctx2_reg.vay, ctx2_reg.ny, dwa_reg)
                                            : ctx2_reg.vay;
            out_data.new_speed_b_x <= upd_b ? upd(ctx2_reg.vbx, ctx2_reg.nx, dwb_reg)
                                            : ctx2_reg.vbx;
            out_data.new_speed_b_y <= upd_b ? upd(ctx2_reg.vby, ctx2_reg.ny, dwb_reg)
                                            : ctx2_reg.vby;
            out_data.resolved      <= ctx2_reg.res;
        end
    end

    assign out_valid = v3_reg;

endmodule

>>> rtl/core/elastic_contact_resolve_2d.sv
// ============================================================================
// elastic_contact_resolve_2d - pipelined 2D two-body elastic contact resolver
// Takes one contact per transaction, returns pushes and new velocities.
// ============================================================================
// Usage:
//   s_valid/s_ready/s_data carry one contact (ecr_in_t) per transaction;
//   m_valid/m_ready/m_data return one result (ecr_out_t) per contact, in
//   order. Both channels use a valid/ready handshake.
//   Throughput: one contact per cycle, with no gaps, while m_ready stays high.
//   Depth: FRAC_BITS + 7 register stages: 2 setup stages, FRAC_BITS + 2
//   divider stages (one quotient bit of the three mass factors per
//   stage), 3 update stages.
//   The divider pipeline sets the depth.
//   Reset (aresetn low, synchronous) clears all stage valid bits; the
//   pipe comes up empty and ready.
//   When m_ready is low the result holds in the output register. Each
//   stage takes a new transaction whenever it is empty or its successor
//   moves, so bubbles close up and the input keeps flowing until the
//   whole pipe is full; nothing is dropped or repeated.
// ============================================================================
module elastic_contact_resolve_2d #(
    parameter int FRAC_BITS = ecr_pkg::ECR_FRAC_BITS
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ecr_pkg::ecr_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output ecr_pkg::ecr_out_t m_data
);
    import ecr_pkg::*;

    // front end -> divider
    logic                 fd_valid, fd_ready;
    ecr_ctx_t             fd_ctx;
    logic [ECR_DEN_W-1:0] fd_den;
    logic [FRAC_BITS+33:0] fd_num_d, fd_num_a, fd_num_b;

    // divider -> back end
    logic                 db_valid, db_ready;
    ecr_ctx_t             db_ctx;
    logic [FRAC_BITS+1:0] db_q_d, db_q_a, db_q_b;

    // normal orientation, normal speeds, pushes, divider numerators
    ecr_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .out_valid (fd_valid),
        .out_ready (fd_ready),
        .out_ctx   (fd_ctx),
        .out_den   (fd_den),
        .out_num_d (fd_num_d),
        .out_num_a (fd_num_a),
        .out_num_b (fd_num_b)
    );

    // rounded mass factors |m1-m2|/sum, 2*m2/sum, 2*m1/sum
    ecr_divider #(.FRAC_BITS(FRAC_BITS)) u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fd_valid),
        .in_ready  (fd_ready),
        .in_ctx    (fd_ctx),
        .in_den    (fd_den),
        .in_num_d  (fd_num_d),
        .in_num_a  (fd_num_a),
        .in_num_b  (fd_num_b),
        .out_valid (db_valid),
        .out_ready (db_ready),
        .out_ctx   (db_ctx),
        .out_q_d   (db_q_d),
        .out_q_a   (db_q_a),
        .out_q_b   (db_q_b)
    );

    // elastic exchange along the normal, saturation, pass-through select
    ecr_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (db_valid),
        .in_ready  (db_ready),
        .in_ctx    (db_ctx),
        .in_q_d    (db_q_d),
        .in_q_a    (db_q_a),
        .in_q_b    (db_q_b),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

endmodule

>>> bench/contact_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// contact_checker - result predictor and scoreboard for the contact resolver
// Watches both channels, computes the expected response of every accepted
// contact and compares each returned result field by field, in order.
// ============================================================================
module contact_checker (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  ecr_pkg::ecr_in_t  s_data,
    input  logic              m_valid,
    input  logic              m_ready,
    input  ecr_pkg::ecr_out_t m_data,
    output int                fail_count,
    output int                pending
);
    import ecr_pkg::*;

    localparam int NB = ECR_NORM_BITS;
    localparam int FB = ECR_FRAC_BITS;

    ecr_out_t response_q[$];

    // floor((x + half) / 2^s)
    function automatic longint round_shift(input longint x, input int s);
        return (x + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic logic signed [31:0] clamp32(input longint x);
        if (x > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (x < -64'sd2147483648) return 32'sh80000000;
        return x[31:0];
    endfunction

    function automatic longint ratio_round(input longint unsigned num,
                                           input longint unsigned den);
        return longint'((num + den / 2) / den);
    endfunction

    function automatic ecr_out_t resolve_contact(input ecr_in_t c);
        ecr_out_t r;
        longint nx, ny, dep, vax, vay, vbx, vby, ua, ub, wa, wb;
        longint pax, pay, pbx, pby, nax, nay, nbx, nby, fd, fca, fcb;
        longint unsigned m1, m2, tot;
        logic ta, sa, tb, sb;
        nx = c.normal_x; ny = c.normal_y; dep = c.depth;
        vax = c.speed_a_x; vay = c.speed_a_y;
        vbx = c.speed_b_x; vby = c.speed_b_y;
        ta = c.body_flags[FLAG_TRIG_A]; sa = c.body_flags[FLAG_STAT_A];
        tb = c.body_flags[FLAG_TRIG_B]; sb = c.body_flags[FLAG_STAT_B];
        pax = 0; pay = 0; pbx = 0; pby = 0;
        nax = vax; nay = vay; nbx = vbx; nby = vby;
        r.resolved = 1'b0;
        if (!ta && !tb && !(sa && sb)) begin
            r.resolved = 1'b1;
            if (nx * longint'(c.offset_x) + ny * longint'(c.offset_y) < 0) begin
                nx = -nx; ny = -ny;
            end
            if (!sa && sb) begin
                pax = round_shift(2 * dep * nx, NB);
                pay = round_shift(2 * dep * ny, NB);
            end
            if (!sb && sa) begin
                pbx = -round_shift(2 * dep * nx, NB);
                pby = -round_shift(2 * dep * ny, NB);
            end
            ua = round_shift(nx * vax + ny * vay, NB);
            ub = round_shift(nx * vbx + ny * vby, NB);
            m1 = c.mass_a; m2 = c.mass_b;
            // both masses zero act as equal masses
            if (m1 + m2 == 0) begin
                m1 = 1; m2 = 1;
            end
            tot = m1 + m2;
            if (m1 >= m2) fd = ratio_round((m1 - m2) << FB, tot);
            else fd = -ratio_round((m2 - m1) << FB, tot);
            fca = ratio_round((2 * m2) << FB, tot);
            fcb = ratio_round((2 * m1) << FB, tot);
            wa = round_shift(fd * ua + fca * ub, FB);
            wb = round_shift(fcb * ua - fd * ub, FB);
            if (!sa) begin
                nax = vax + round_shift(nx * (wa - ua), NB);
                nay = vay + round_shift(ny * (wa - ua), NB);
            end
            if (!sb) begin
                nbx = vbx + round_shift(nx * (wb - ub), NB);
                nby = vby + round_shift(ny * (wb - ub), NB);
            end
        end
        r.push_a_x = clamp32(pax); r.push_a_y = clamp32(pay);
        r.push_b_x = clamp32(pbx); r.push_b_y = clamp32(pby);
        r.new_speed_a_x = clamp32(nax); r.new_speed_a_y = clamp32(nay);
        r.new_speed_b_x = clamp32(nbx); r.new_speed_b_y = clamp32(nby);
        return r;
    endfunction

    task automatic check_field(input string nm, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, nm,
                     $signed(exp_v), $signed(act_v));
        end
    endtask

    initial begin
        fail_count = 0;
        pending = 0;
    end

    always @(posedge aclk) begin
        ecr_out_t e;
        if (aresetn && s_valid && s_ready)
            response_q.push_back(resolve_contact(s_data));
        if (aresetn && m_valid && m_ready) begin
            if (response_q.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected result, expected none actual %h", $time, m_data);
            end else begin
                e = response_q.pop_front();
                check_field("push_a_x", e.push_a_x, m_data.push_a_x);
                check_field("push_a_y", e.push_a_y, m_data.push_a_y);
                check_field("push_b_x", e.push_b_x, m_data.push_b_x);
                check_field("push_b_y", e.push_b_y, m_data.push_b_y);
                check_field("new_speed_a_x", e.new_speed_a_x, m_data.new_speed_a_x);
                check_field("new_speed_a_y", e.new_speed_a_y, m_data.new_speed_a_y);
                check_field("new_speed_b_x", e.new_speed_b_x, m_data.new_speed_b_x);
                check_field("new_speed_b_y", e.new_speed_b_y, m_data.new_speed_b_y);
                check_field("resolved", 32'(e.resolved), 32'(m_data.resolved));
            end
        end
        pending = response_q.size();
    end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top - testbench for the 2D elastic contact resolver
// Sends directed corner contacts and then random ones through the block
// under varying sender gaps and receiver stalls; the checker predicts and
// compares every result.
// ============================================================================
module tb_top;
    import ecr_pkg::*;

    localparam int IN_W = $bits(ecr_in_t);

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    ecr_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    ecr_out_t m_data;
    int       fail_count;
    int       pending;

    // idle odds in percent, per side, set per phase
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;
    bit       hold_off = 1'b0;   // receiver pinned low for the fill-up test

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    elastic_contact_resolve_2d uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    contact_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .fail_count(fail_count), .pending(pending)
    );

    // Receiver: random stalls, forced low during hold-off.
    always @(posedge aclk) begin
        if (hold_off) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Random unit-ish normal: one axis at unit length (1.0 in Q2.14) or a random pair.
    function automatic ecr_in_t random_contact();
        ecr_in_t c;
        int unsigned pick;
        c = ecr_in_t'(IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom, $urandom, $urandom}));
        pick = $urandom_range(3);
        case (pick)
            0: begin
                c.normal_x = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
                c.normal_y = 16'sd0;
            end
            1: begin
                c.normal_x = 16'sd0;
                c.normal_y = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
            end
            default: begin
                c.normal_x = 16'($signed($urandom_range(32768)) - 16384);
                c.normal_y = 16'($signed($urandom_range(32768)) - 16384);
            end
        endcase
        if ($urandom_range(1)) begin
            // moderate magnitudes exercise the unsaturated arithmetic
            c.speed_a_x = 32'($signed($urandom_range(2000000)) - 1000000);
            c.speed_a_y = 32'($signed($urandom_range(2000000)) - 1000000);
            c.speed_b_x = 32'($signed($urandom_range(2000000)) - 1000000);
            c.speed_b_y = 32'($signed($urandom_range(2000000)) - 1000000);
            c.depth = 31'($urandom_range(200000));
            c.mass_a = $urandom_range(1000000, 1);
            c.mass_b = $urandom_range(1000000, 1);
        end
        if (c.mass_a == 32'd0) c.mass_a = 32'd1;
        if (c.mass_b == 32'd0) c.mass_b = 32'd1;
        // mostly resolvable contacts; flags otherwise random
        if ($urandom_range(99) < 70) c.body_flags = 4'($urandom_range(1) << 1) |
                                                    4'($urandom_range(1) << 3);
        if (c.body_flags == 4'b1010 && $urandom_range(1)) c.body_flags = 4'b0000;
        return c;
    endfunction

    // Valid drops only in idle cycles, so back-to-back transactions keep it high.
    task automatic send_contact(input ecr_in_t c);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= c;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic directed_contacts();
        ecr_in_t c;
        for (int i = 0; i < 16; i++) begin
            c = '0;
            c.normal_x = 16'sd16384;
            c.offset_x = (i % 2) ? -32'sd65536 : 32'sd65536;
            c.depth = 31'h7FFFFFFF;
            c.speed_a_x = 32'sh7FFFFFFF;
            c.speed_b_x = 32'sh80000000;
            c.speed_a_y = 32'sd1000;
            c.mass_a = 32'hFFFFFFFF;
            c.mass_b = 32'd1;
            c.body_flags = 4'(i);
            send_contact(c);
        end
        c = '0;                          // zero dot product, equal masses
        c.normal_x = -16'sd16384; c.mass_a = 32'd1; c.mass_b = 32'd1;
        c.speed_a_x = 32'sd65536; c.speed_b_x = -32'sd65536;
        send_contact(c);
        c.normal_x = 16'sd11585; c.normal_y = -16'sd11585;   // diagonal
        c.offset_y = 32'sh80000000; c.depth = 31'd65536;
        c.mass_a = 32'h00010000; c.mass_b = 32'h00030000; c.body_flags = 4'b1000;
        send_contact(c);
        c.normal_x = 16'sd16384; c.normal_y = 16'sd16384;     // non-unit normal
        c.speed_a_y = 32'sh80000000; c.body_flags = 4'b0010;
        send_contact(c);
        c.mass_a = 32'hFFFFFFFF; c.mass_b = 32'hFFFFFFFF; c.body_flags = 4'd0;
        send_contact(c);
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        directed_contacts();
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 1) ? 79 : 32) : 0;
            recv_stall_pct = (ph == 2) ? 79 : ((ph == 3) ? 32 : 0);
            for (int n = 0; n < 125; n++) send_contact(random_contact());
        end

        // Fill-up: receiver held off while contacts keep coming.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        fork
            begin
                hold_off = 1'b1;
                repeat (60) @(posedge aclk);
                hold_off = 1'b0;
            end
            for (int n = 0; n < 40; n++) send_contact(random_contact());
        join
        s_valid <= 1'b0;

        while (pending != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
